// ----- rtl/swrmt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrmt_pkg
// Shared widths, codes and word types of the sweep SWR minimum tracker.
// ----------------------------------------------------------------------------
package swrmt_pkg;

  localparam int ADC_BITS         = 12;
  localparam int FREQ_W           = 26;
  localparam int SWR_W            = 18;
  localparam int TW_W             = 32;
  localparam int SWR_FRAC         = 8;
  localparam int FLOOR_W          = 12;
  localparam int SUM_W            = ADC_BITS + 1;
  localparam int SWR_NUM_W        = SUM_W + SWR_FRAC;
  localparam int TW_NUM_W         = FREQ_W + TW_W;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 18;
  localparam int QUEUE_DEPTH      = 2;
  localparam int REF_CLOCK_HZ_DEF = 125000000;

  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(13);
  localparam logic [SWR_W-1:0]   CEIL_RESET  = SWR_W'(255744);

  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_FLOOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWR_CEILING   = 2'd1;

  localparam logic [1:0] STAT_NORMAL    = 2'd0;
  localparam logic [1:0] STAT_NO_SIGNAL = 2'd1;
  localparam logic [1:0] STAT_REFLECTED = 2'd2;
  localparam logic [1:0] STAT_CLAMP     = 2'd3;

  typedef struct packed {
    logic                first_of_sweep;
    logic [FREQ_W-1:0]   frequency_hz;
    logic [ADC_BITS-1:0] forward_count;
    logic [ADC_BITS-1:0] reflected_count;
  } in_word_t;

  typedef struct packed {
    logic [SWR_W-1:0]  swr_value;
    logic [1:0]        swr_status;
    logic [SWR_W-1:0]  best_swr;
    logic [FREQ_W-1:0] best_frequency_hz;
    logic [TW_W-1:0]   best_tuning_word;
  } out_word_t;

  typedef struct packed {
    logic                 first_of_sweep;
    logic [FREQ_W-1:0]    frequency_hz;
    logic [SWR_NUM_W-1:0] num;
    logic [ADC_BITS-1:0]  den;
    logic [1:0]           cls;
  } q_entry_t;

endpackage
`default_nettype wire

// ----- rtl/swr_sweep_minimum_tracker.sv -----
// Flow: each word is queued in the front; the back takes one point at a time,
//   divides out the SWR in the bit-serial SWR divider (21 quotient bits) unless
//   the point is no-signal or reflected-high, derives the tuning word when the
//   point sets a new sweep minimum, and loads the result word.
// Reset: synchronous, active low; loads the register defaults, sets the minimum
//   to 999.0 at 0 Hz and empties the queue. No clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// swr_sweep_minimum_tracker
// SWR per sweep point from forward and reflected detector counts, with the
// running minimum, its frequency and its DDS tuning word.
// ----------------------------------------------------------------------------
module swr_sweep_minimum_tracker
  import swrmt_pkg::*;
#(
  parameter int REF_CLOCK_HZ = REF_CLOCK_HZ_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_word_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_word_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [FLOOR_W-1:0] forward_floor_r;
  logic [SWR_W-1:0]   swr_ceiling_r;
  logic               q_valid;
  logic               q_ready;
  q_entry_t           q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      forward_floor_r <= FLOOR_RESET;
      swr_ceiling_r   <= CEIL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FORWARD_FLOOR: forward_floor_r <= cfg_data[FLOOR_W-1:0];
        CFG_SWR_CEILING:   swr_ceiling_r   <= cfg_data[SWR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  swrmt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .forward_floor (forward_floor_r),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_data        (q_data)
  );

  swrmt_back #(
    .REF_CLOCK_HZ (REF_CLOCK_HZ)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_data      (q_data),
    .swr_ceiling (swr_ceiling_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/swrmt_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrmt_div
// Restoring divider, one quotient bit per cycle. The top PRE dividend bits
// are known to give zero quotient bits and are loaded straight into the
// remainder.
// ----------------------------------------------------------------------------
module swrmt_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 12,
  parameter int QUO_W = 21,
  parameter int PRE   = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [QUO_W-1:0]      quo
);

  localparam int STEPS = NUM_W - PRE;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] sh_r;
  logic [QUO_W-1:0] quo_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, sh_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DEN_W'(num >> (NUM_W - PRE));
      sh_r  <= num << PRE;
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      sh_r  <= sh_r << 1;
      quo_r <= {quo_r[QUO_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule
`default_nettype wire

// ----- rtl/swrmt_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrmt_front
// Accepts sweep points, sorts out no-signal and reflected-high cases, forms
// the SWR dividend and divisor, and holds the result in a short queue.
// ----------------------------------------------------------------------------
module swrmt_front
  import swrmt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_word_t           in_data,
  input  wire logic [FLOOR_W-1:0] forward_floor,
  output logic                    q_valid,
  input  wire logic               q_ready,
  output q_entry_t                q_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t         q_mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  q_entry_t         entry;
  logic             push;
  logic             pop;
  logic [SUM_W-1:0] sum;

  always_comb begin
    sum                  = SUM_W'(in_data.forward_count) + SUM_W'(in_data.reflected_count);
    entry.first_of_sweep = in_data.first_of_sweep;
    entry.frequency_hz   = in_data.frequency_hz;
    entry.num            = {sum, SWR_FRAC'(0)};
    entry.den            = in_data.forward_count - in_data.reflected_count;
    if (in_data.forward_count < forward_floor) begin
      entry.cls = STAT_NO_SIGNAL;
    end else if (in_data.reflected_count >= in_data.forward_count) begin
      entry.cls = STAT_REFLECTED;
    end else begin
      entry.cls = STAT_NORMAL;
    end
  end

  assign in_ready = cnt_r != CNT_W'(QUEUE_DEPTH);
  assign q_valid  = cnt_r != '0;
  assign q_data   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/swrmt_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrmt_back
// Divides out the SWR, clamps it, updates the sweep minimum, derives the
// tuning word of a new minimum and presents the result word.
// ----------------------------------------------------------------------------
module swrmt_back
  import swrmt_pkg::*;
#(
  parameter int REF_CLOCK_HZ = REF_CLOCK_HZ_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire q_entry_t         q_data,
  input  wire logic [SWR_W-1:0] swr_ceiling,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_word_t             out_data
);

  localparam int TW_DEN_W = $clog2(REF_CLOCK_HZ + 1);
  localparam int TW_Q_W   = TW_NUM_W - TW_DEN_W + 1;
  localparam int TW_P1_W  = FREQ_W + TW_Q_W;
  localparam int TW_EXT_W = TW_NUM_W + 1;
  localparam logic [TW_EXT_W-1:0] TW_DIV   = TW_EXT_W'(REF_CLOCK_HZ);
  localparam logic [TW_Q_W-1:0]   TW_RECIP =
    TW_Q_W'({1'b1, {TW_NUM_W{1'b0}}} / TW_DIV);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SWR  = 5'b00010,
    ST_EVAL = 5'b00100,
    ST_TW   = 5'b01000,
    ST_OUT  = 5'b10000
  } back_state_t;

  back_state_t          state_r;
  back_state_t          state_nxt;
  q_entry_t             cur_r;
  logic [SWR_W-1:0]     swr_r;
  logic [1:0]           stat_r;
  logic [SWR_W-1:0]     lowest_swr_r;
  logic [FREQ_W-1:0]    lowest_freq_r;
  logic [TW_W-1:0]      tw_r;
  logic                 out_valid_r;
  out_word_t            out_data_r;
  logic [1:0]           tw_stage_r;
  logic [TW_P1_W-1:0]   tw_prod_r;
  logic [TW_Q_W-1:0]    tw_est_r;
  logic [TW_EXT_W-1:0]  tw_back_r;
  logic                 swr_start;
  logic                 tw_start;
  logic                 out_load;
  logic                 swr_done;
  logic                 tw_done;
  logic [SWR_NUM_W-1:0] swr_quo;
  logic [TW_W-1:0]      tw_quo;
  logic [TW_Q_W-1:0]    tw_est;
  logic [TW_EXT_W-1:0]  tw_rem;
  logic                 tw_up;
  logic [SWR_W-1:0]     base_swr;
  logic [FREQ_W-1:0]    base_freq;
  logic                 new_min;

  swrmt_div #(
    .NUM_W (SWR_NUM_W),
    .DEN_W (ADC_BITS),
    .QUO_W (SWR_NUM_W),
    .PRE   (0)
  ) u_swr_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (swr_start),
    .num   (q_data.num),
    .den   (q_data.den),
    .done  (swr_done),
    .quo   (swr_quo)
  );

  // reciprocal estimate is at most one low; one remainder check settles it
  assign tw_est  = tw_prod_r[TW_P1_W-1:FREQ_W];
  assign tw_rem  = {1'b0, cur_r.frequency_hz, TW_W'(0)} - tw_back_r;
  assign tw_up   = tw_rem >= TW_DIV;
  assign tw_done = tw_stage_r[1];
  assign tw_quo  = TW_W'(tw_est_r + TW_Q_W'(tw_up));

  assign base_swr  = cur_r.first_of_sweep ? swr_ceiling : lowest_swr_r;
  assign base_freq = cur_r.first_of_sweep ? '0 : lowest_freq_r;
  assign new_min   = swr_r < base_swr;

  always_comb begin
    state_nxt = state_r;
    q_ready   = 1'b0;
    swr_start = 1'b0;
    tw_start  = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_ready   = 1'b1;
          swr_start = q_data.cls == STAT_NORMAL;
          state_nxt = swr_start ? ST_SWR : ST_EVAL;
        end
      end
      ST_SWR: begin
        if (swr_done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (new_min) begin
          tw_start  = 1'b1;
          state_nxt = ST_TW;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_TW: begin
        if (tw_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
      lowest_swr_r  <= CEIL_RESET;
      lowest_freq_r <= '0;
      tw_r          <= '0;
      tw_stage_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      tw_stage_r <= {tw_stage_r[0], tw_start};
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_EVAL) begin
        lowest_swr_r  <= new_min ? swr_r : base_swr;
        lowest_freq_r <= new_min ? cur_r.frequency_hz : base_freq;
        if (!new_min && cur_r.first_of_sweep) begin
          tw_r <= '0;
        end
      end
      if (state_r == ST_TW && tw_done) begin
        tw_r <= tw_quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur_r  <= q_data;
      swr_r  <= swr_ceiling;
      stat_r <= q_data.cls;
    end
    if (state_r == ST_SWR && swr_done) begin
      if (swr_quo > SWR_NUM_W'(swr_ceiling)) begin
        swr_r  <= swr_ceiling;
        stat_r <= STAT_CLAMP;
      end else begin
        swr_r  <= swr_quo[SWR_W-1:0];
        stat_r <= STAT_NORMAL;
      end
    end
    if (tw_start) begin
      tw_prod_r <= TW_P1_W'(cur_r.frequency_hz) * TW_P1_W'(TW_RECIP);
    end
    if (tw_stage_r[0]) begin
      tw_est_r  <= tw_est;
      tw_back_r <= TW_EXT_W'(tw_est) * TW_DIV;
    end
    if (out_load) begin
      out_data_r.swr_value         <= swr_r;
      out_data_r.swr_status        <= stat_r;
      out_data_r.best_swr          <= lowest_swr_r;
      out_data_r.best_frequency_hz <= lowest_freq_r;
      out_data_r.best_tuning_word  <= tw_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- rtl/swrmt_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// swrmt_checker
// Port-level checks of the result channel of the SWR minimum tracker.
// ----------------------------------------------------------------------------
module swrmt_checker
  import swrmt_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

  a_best_le_point: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.best_swr <= out_data.swr_value)
    else $error("sweep minimum above the point just taken");

  a_zero_freq_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.best_frequency_hz == '0 |-> out_data.best_tuning_word == '0)
    else $error("tuning word nonzero at 0 Hz");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind swr_sweep_minimum_tracker swrmt_checker u_swrmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
